[rtl/core/llb_pkg.sv]
package llb_pkg;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 13;
  localparam int LIT_W      = 3;
  localparam int MASK_W     = 4;
  localparam int THR_W      = 12;
  localparam int HYST_W     = 10;
  localparam int OFS_W      = 11;
  localparam int EFF_W      = 14;
  localparam int NUM_LEDS   = 4;

  // Port widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  // Window and queue sizing
  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int SAMPLE_MAX       = 4095;

  // Rounding to tens: (mean + 5) * 6554 >> 16 gives (mean + 5) / 10
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_TEN  = 13'd6554;
  localparam logic [LEVEL_W-1:0] ROUND_HALF = 13'd5;
  localparam logic [LEVEL_W-1:0] TEN        = 13'd10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd5;

  // Register reset values
  localparam logic [THR_W-1:0]  THR_ONE_RST   = 12'd3000;
  localparam logic [THR_W-1:0]  THR_TWO_RST   = 12'd2300;
  localparam logic [THR_W-1:0]  THR_THREE_RST = 12'd1600;
  localparam logic [THR_W-1:0]  THR_FOUR_RST  = 12'd900;
  localparam logic [HYST_W-1:0] HYST_RST      = 10'd150;
  localparam logic [OFS_W-1:0]  OFFSET_RST    = 11'd0;

  typedef struct packed {
    logic [THR_W-1:0]  thr_one;
    logic [THR_W-1:0]  thr_two;
    logic [THR_W-1:0]  thr_three;
    logic [THR_W-1:0]  thr_four;
    logic [HYST_W-1:0] hyst;
    logic [OFS_W-1:0]  offset;
  } cfg_t;

endpackage

[rtl/core/light_level_bar_with_hysteresis_top.sv]
// Channel | Direction | Handshake          | Payload
// in      | input     | in_tvalid/tready   | in_tdata[11:0] light_sample
// out     | output    | out_tvalid/tready  | out_tdata: light_level, lit_count, led_mask
// cfg     | input     | cfg_valid/ready    | cfg_index register, cfg_data value
//
// The front side takes a new item only once the last one is stored, and only while its two-entry queue has room.
// The back side takes one item at a time through divide, scale, round and compare; the
// one-bit-per-cycle divider divides the window total by the fill count.
// Reset is synchronous; ring entries not yet written read as zero by the fill state,
// so no clearing pass runs. The output register lets the back side work on the next item while a
// result waits; a full queue stalls in_tready.
module light_level_bar_with_hysteresis_top #(
  parameter int WINDOW_DEPTH = llb_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [11:0] light_sample
  input  logic [llb_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [12:0] light_level, [15:13] lit_count, [19:16] led_mask
  output logic [llb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [llb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [llb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int TOTAL_W = $clog2(WINDOW_DEPTH * llb_pkg::SAMPLE_MAX + 1);
  localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int JOB_W   = TOTAL_W + COUNT_W;

  llb_pkg::cfg_t      cfg_r;
  logic               q_push;
  logic [JOB_W-1:0]   q_wdata;
  logic               q_not_full;
  logic               q_valid;
  logic               q_pop;
  logic [JOB_W-1:0]   q_rdata;

  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr_one   <= llb_pkg::THR_ONE_RST;
      cfg_r.thr_two   <= llb_pkg::THR_TWO_RST;
      cfg_r.thr_three <= llb_pkg::THR_THREE_RST;
      cfg_r.thr_four  <= llb_pkg::THR_FOUR_RST;
      cfg_r.hyst      <= llb_pkg::HYST_RST;
      cfg_r.offset    <= llb_pkg::OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        llb_pkg::REG_THR_ONE:   cfg_r.thr_one   <= cfg_data;
        llb_pkg::REG_THR_TWO:   cfg_r.thr_two   <= cfg_data;
        llb_pkg::REG_THR_THREE: cfg_r.thr_three <= cfg_data;
        llb_pkg::REG_THR_FOUR:  cfg_r.thr_four  <= cfg_data;
        llb_pkg::REG_HYST:      cfg_r.hyst      <= cfg_data[llb_pkg::HYST_W-1:0];
        llb_pkg::REG_OFFSET:    cfg_r.offset    <= cfg_data[llb_pkg::OFS_W-1:0];
        default: ;
      endcase
    end
  end

  llb_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  llb_fifo #(
    .W (JOB_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .not_full  (q_not_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_rdata)
  );

  llb_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/core/llb_fifo.sv]
module llb_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         not_full,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = $clog2(llb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(llb_pkg::QUEUE_DEPTH + 1);

  logic [W-1:0]     slot_r [llb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign not_full  = (cnt_r != CNT_W'(llb_pkg::QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && pop_valid;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(llb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(llb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/llb_front.sv]
module llb_front #(
  parameter int WINDOW_DEPTH = llb_pkg::WINDOW_DEPTH_DEF,
  localparam int TOTAL_W = $clog2(WINDOW_DEPTH * llb_pkg::SAMPLE_MAX + 1),
  localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1),
  localparam int JOB_W   = TOTAL_W + COUNT_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [llb_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           q_not_full,
  output logic                           q_push,
  output logic [JOB_W-1:0]               q_data
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } front_state_t;

  front_state_t                   state_r, state_nxt;
  logic [llb_pkg::SAMPLE_W-1:0]   ring [WINDOW_DEPTH];
  logic [llb_pkg::SAMPLE_W-1:0]   old_r;
  logic [llb_pkg::SAMPLE_W-1:0]   sample_r;
  logic [SLOT_W-1:0]              slot_r, slot_nxt;
  logic [TOTAL_W-1:0]             total_r, total_nxt;
  logic                           full_r, full_nxt;
  logic [llb_pkg::SAMPLE_W-1:0]   old_eff;
  logic [COUNT_W-1:0]             count;
  logic                           accept;

  assign in_tready = (state_r == F_IDLE) && q_not_full;
  assign accept    = in_tvalid && in_tready;

  // Read the outgoing entry and write the new sample
  always_ff @(posedge clk) begin
    if (accept) begin
      old_r    <= ring[slot_r];
      sample_r <= in_tdata[llb_pkg::SAMPLE_W-1:0];
    end
    if (state_r == F_UPD) begin
      ring[slot_r] <= sample_r;
    end
  end

  // Update window total, slot and fill state
  always_comb begin
    old_eff   = full_r ? old_r : '0;
    total_nxt = total_r - TOTAL_W'(old_eff) + TOTAL_W'(sample_r);
    slot_nxt  = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    full_nxt  = full_r || (slot_nxt == '0);
    count     = full_nxt ? COUNT_W'(WINDOW_DEPTH) : COUNT_W'(slot_nxt);
    q_push    = (state_r == F_UPD);
    q_data    = {count, total_nxt};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = F_UPD;
      end
      F_UPD: begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      slot_r  <= '0;
      total_r <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_UPD) begin
        slot_r  <= slot_nxt;
        total_r <= total_nxt;
        full_r  <= full_nxt;
      end
    end
  end

endmodule

[rtl/core/llb_back.sv]
module llb_back #(
  parameter int WINDOW_DEPTH = llb_pkg::WINDOW_DEPTH_DEF,
  localparam int TOTAL_W = $clog2(WINDOW_DEPTH * llb_pkg::SAMPLE_MAX + 1),
  localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1),
  localparam int JOB_W   = TOTAL_W + COUNT_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  llb_pkg::cfg_t                   cfg,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  logic [JOB_W-1:0]                q_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [llb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int STEP_W = $clog2(TOTAL_W);
  localparam int PROD_W = llb_pkg::LEVEL_W + llb_pkg::RECIP_W;
  localparam int QT_W   = PROD_W - llb_pkg::RECIP_SHIFT;
  localparam int PAD_W  = llb_pkg::OUT_TDATA_W - llb_pkg::LEVEL_W - llb_pkg::LIT_W
                          - llb_pkg::MASK_W;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_DIV   = 5'b00010,
    B_SCALE = 5'b00100,
    B_ROUND = 5'b01000,
    B_CMP   = 5'b10000
  } back_state_t;

  back_state_t                    state_r, state_nxt;
  logic [COUNT_W-1:0]             rem_r;
  logic [TOTAL_W-1:0]             quo_r;
  logic [COUNT_W-1:0]             div_r;
  logic [STEP_W-1:0]              step_r;
  logic [PROD_W-1:0]              prod_r;
  logic [llb_pkg::LEVEL_W-1:0]    level_r;
  logic [llb_pkg::LIT_W-1:0]      prev_lit_r;
  logic                           out_valid_r;
  logic [llb_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [COUNT_W:0]               shifted;
  logic [COUNT_W:0]               diff;
  logic [COUNT_W-1:0]             rem_nxt;
  logic                           qbit;
  logic [llb_pkg::LEVEL_W-1:0]    mean_half;
  logic [QT_W-1:0]                tens;
  logic [llb_pkg::LEVEL_W-1:0]    tens_ext;
  logic signed [llb_pkg::EFF_W-1:0] thr [llb_pkg::NUM_LEDS];
  logic signed [llb_pkg::EFF_W-1:0] eff;
  logic signed [llb_pkg::EFF_W-1:0] ofs_ext;
  logic signed [llb_pkg::EFF_W-1:0] lvl_ext;
  logic [llb_pkg::LIT_W-1:0]      lit;
  logic [llb_pkg::MASK_W-1:0]     mask;
  logic                           out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign q_pop      = (state_r == B_IDLE) && q_valid;

  // One restoring divide step: remainder stays below the divisor
  always_comb begin
    shifted = {rem_r, quo_r[TOTAL_W-1]};
    diff    = shifted - {1'b0, div_r};
    qbit    = !diff[COUNT_W];
    rem_nxt = qbit ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
  end

  // Round the mean to tens by reciprocal multiply
  always_comb begin
    mean_half = {1'b0, quo_r[llb_pkg::SAMPLE_W-1:0]} + llb_pkg::ROUND_HALF;
    tens      = prod_r[PROD_W-1:llb_pkg::RECIP_SHIFT];
    tens_ext  = llb_pkg::LEVEL_W'(tens);
  end

  // Compare level against each threshold, highest passing LED wins
  always_comb begin
    thr[0]  = $signed({2'b00, cfg.thr_one});
    thr[1]  = $signed({2'b00, cfg.thr_two});
    thr[2]  = $signed({2'b00, cfg.thr_three});
    thr[3]  = $signed({2'b00, cfg.thr_four});
    ofs_ext = $signed({{(llb_pkg::EFF_W - llb_pkg::OFS_W){cfg.offset[llb_pkg::OFS_W-1]}},
                       cfg.offset});
    lvl_ext = $signed({1'b0, level_r});
    lit     = '0;
    eff     = '0;
    for (int i = 0; i < llb_pkg::NUM_LEDS; i++) begin
      eff = thr[i] + ofs_ext;
      if (prev_lit_r > llb_pkg::LIT_W'(i)) begin
        eff = eff + $signed({4'b0000, cfg.hyst});
      end
      if (lvl_ext < eff) begin
        lit = llb_pkg::LIT_W'(i + 1);
      end
    end
    for (int i = 0; i < llb_pkg::MASK_W; i++) begin
      mask[i] = (llb_pkg::LIT_W'(i) < lit);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) state_nxt = B_DIV;
      end
      B_DIV: begin
        if (step_r == '0) state_nxt = B_SCALE;
      end
      B_SCALE: state_nxt = B_ROUND;
      B_ROUND: state_nxt = B_CMP;
      B_CMP: begin
        if (out_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem_r  <= '0;
      quo_r  <= q_data[TOTAL_W-1:0];
      div_r  <= q_data[JOB_W-1:TOTAL_W];
      step_r <= STEP_W'(TOTAL_W - 1);
    end else if (state_r == B_DIV) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[TOTAL_W-2:0], qbit};
      step_r <= step_r - 1'b1;
    end
    if (state_r == B_SCALE) begin
      prod_r <= mean_half * llb_pkg::RECIP_TEN;
    end
    if (state_r == B_ROUND) begin
      level_r <= tens_ext * llb_pkg::TEN;
    end
    if (state_r == B_CMP && out_free) begin
      out_data_r <= {{PAD_W{1'b0}}, mask, lit, level_r};
    end
  end

  // Control: state, LED history and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      prev_lit_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CMP && out_free) begin
        prev_lit_r  <= lit;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
